[rtl/assert_macros.svh]
// Assertion macros used by the detector core.
// With SYNTH defined, every macro expands to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked on every rising clock edge outside reset.
`define KSLP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked on every rising clock edge outside reset.
`define KSLP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define KSLP_ASSERT_NOW(label, clk, rst, ante, cons)
`define KSLP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/kslpd_pkg.sv]
package kslpd_pkg;

  // Fixed field widths.
  localparam int LevelW = 4;
  localparam int CodeW  = 4;
  localparam int TicksW = 16;

  // Default number of keys.
  localparam int DefKeys = 4;

  // Reset value of the long-press threshold.
  localparam logic [TicksW-1:0] TicksReset = 16'd100;

  // Item action codes.
  localparam logic ActScan = 1'b0;
  localparam logic ActPoll = 1'b1;

endpackage

[rtl/kslpd_req_if.sv]
// Input channel: scan ticks and polls.
interface kslpd_req_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [kslpd_pkg::LevelW-1:0]  key_levels;

  modport source (output valid, output action, output key_levels, input ready);
  modport sink   (input valid, input action, input key_levels, output ready);
endinterface

[rtl/kslpd_rsp_if.sv]
// Output channel: one event code per poll.
interface kslpd_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [kslpd_pkg::CodeW-1:0]  event_code;

  modport source (output valid, output event_code, input ready);
  modport sink   (input valid, input event_code, output ready);
endinterface

[rtl/kslpd_cfg_if.sv]
// Configuration write channel for the long-press threshold.
interface kslpd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [kslpd_pkg::TicksW-1:0]  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/key_short_long_press_detector_core.sv]
// Short/long key-press detector for KEYS keys. Every key updates side by side, so the
// block takes one item per clock cycle: a scan tick (action 0) steps all key machines
// and returns nothing, and a poll (action 1) returns one event code through an output
// register backed by a one-entry skid register. The input drops ready only while the
// skid register holds a result, so a stalled output costs at most one extra item of
// buffering. Codes for key k: short k+1, long k+1+KEYS, long release k+1+2*KEYS,
// masked to four bits; 0 means nothing pending.
// The threshold register takes a write in every cycle.
`include "assert_macros.svh"

module key_short_long_press_detector_core #(
  parameter int KEYS = kslpd_pkg::DefKeys
) (
  input  logic        clk,
  input  logic        rst,
  kslpd_req_if.sink   req,
  kslpd_rsp_if.source rsp,
  kslpd_cfg_if.sink   cfg
);

  localparam int SelW      = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int LevelIdxW = $clog2(kslpd_pkg::LevelW);
  localparam int CodeRawW  = ($clog2(3 * KEYS + 1) > kslpd_pkg::CodeW) ?
                             $clog2(3 * KEYS + 1) : kslpd_pkg::CodeW;

  typedef enum logic [1:0] {
    PH_RELEASED = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_LONG     = 2'd2
  } phase_t;

  // Key state.
  phase_t                         key_phase [KEYS];
  logic [kslpd_pkg::TicksW-1:0]   hold_count [KEYS];
  logic [KEYS-1:0]                short_pending;
  logic [KEYS-1:0]                long_active;
  logic [KEYS-1:0]                long_release_pending;
  logic [kslpd_pkg::TicksW-1:0]   long_press_ticks;

  phase_t                         key_phase_next [KEYS];
  logic [kslpd_pkg::TicksW-1:0]   hold_count_next [KEYS];
  logic [KEYS-1:0]                short_pending_next;
  logic [KEYS-1:0]                long_active_next;
  logic [KEYS-1:0]                long_release_pending_next;

  // Output register and skid register.
  logic                           out_valid;
  logic [kslpd_pkg::CodeW-1:0]    out_code;
  logic                           skid_valid;
  logic [kslpd_pkg::CodeW-1:0]    skid_code;

  logic                           req_fire;
  logic                           scan_fire;
  logic                           poll_fire;
  logic [KEYS-1:0]                key_down;
  logic [KEYS-1:0]                pending;
  logic                           any_pending;
  logic [SelW-1:0]                sel;
  logic [CodeRawW-1:0]            code_raw;
  logic [kslpd_pkg::CodeW-1:0]    poll_code;
  logic [KEYS-1:0]                phase_long;
  logic [kslpd_pkg::TicksW-1:0]   hold_inc;

  assign req.ready  = ~skid_valid;
  assign cfg.ready  = 1'b1;
  assign rsp.valid  = out_valid;
  assign rsp.event_code = out_code;

  assign req_fire  = req.valid & req.ready;
  assign scan_fire = req_fire & (req.action == kslpd_pkg::ActScan);
  assign poll_fire = req_fire & (req.action == kslpd_pkg::ActPoll);

  // Pressed keys from the active-low pins; keys past the pin field never press.
  always_comb begin
    key_down = '0;
    for (int k = 0; k < KEYS; k++) begin
      if (k < kslpd_pkg::LevelW) begin
        key_down[k] = ~req.key_levels[k[LevelIdxW-1:0]];
      end
    end
  end

  // First key with any pending event, lowest index wins.
  always_comb begin
    sel = '0;
    any_pending = 1'b0;
    for (int k = KEYS - 1; k >= 0; k--) begin
      pending[k] = short_pending[k] | long_active[k] | long_release_pending[k];
      if (pending[k]) begin
        sel = SelW'(k);
        any_pending = 1'b1;
      end
    end
  end

  // Event code of the selected key, by the short, long, long-release order.
  always_comb begin
    if (!any_pending) begin
      code_raw = '0;
    end else if (short_pending[sel]) begin
      code_raw = CodeRawW'(sel) + CodeRawW'(1);
    end else if (long_active[sel]) begin
      code_raw = CodeRawW'(sel) + CodeRawW'(1) + CodeRawW'(KEYS);
    end else begin
      code_raw = CodeRawW'(sel) + CodeRawW'(1) + CodeRawW'(2 * KEYS);
    end
    poll_code = code_raw[kslpd_pkg::CodeW-1:0];
  end

  // Next key state for scan ticks and the clear-on-read flags of polls.
  always_comb begin
    short_pending_next        = short_pending;
    long_active_next          = long_active;
    long_release_pending_next = long_release_pending;
    hold_inc = '0;
    for (int k = 0; k < KEYS; k++) begin
      key_phase_next[k]  = key_phase[k];
      hold_count_next[k] = hold_count[k];
      phase_long[k]      = (key_phase[k] == PH_LONG);
      if (scan_fire) begin
        case (key_phase[k])
          PH_PRESSED: begin
            if (!key_down[k]) begin
              short_pending_next[k] = 1'b1;
              key_phase_next[k]     = PH_RELEASED;
            end else begin
              hold_inc = (hold_count[k] != '1) ? hold_count[k] + 1'b1 : hold_count[k];
              hold_count_next[k] = hold_inc;
              if (hold_inc >= long_press_ticks) begin
                long_active_next[k] = 1'b1;
                key_phase_next[k]   = PH_LONG;
              end
            end
          end
          PH_LONG: begin
            if (!key_down[k]) begin
              long_release_pending_next[k] = 1'b1;
              long_active_next[k]          = 1'b0;
              key_phase_next[k]            = PH_RELEASED;
            end
          end
          default: begin
            if (key_down[k]) begin
              hold_count_next[k]  = '0;
              long_active_next[k] = 1'b0;
              key_phase_next[k]   = PH_PRESSED;
            end
          end
        endcase
      end
    end
    // A poll clears the flag that it returns, unless that flag is the long level.
    if (poll_fire && any_pending) begin
      if (short_pending[sel]) begin
        short_pending_next[sel] = 1'b0;
      end else if (!long_active[sel]) begin
        long_release_pending_next[sel] = 1'b0;
      end
    end
  end

  // Key state registers and the threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      short_pending        <= '0;
      long_active          <= '0;
      long_release_pending <= '0;
      long_press_ticks     <= kslpd_pkg::TicksReset;
      for (int k = 0; k < KEYS; k++) begin
        key_phase[k]  <= PH_RELEASED;
        hold_count[k] <= '0;
      end
    end else begin
      short_pending        <= short_pending_next;
      long_active          <= long_active_next;
      long_release_pending <= long_release_pending_next;
      for (int k = 0; k < KEYS; k++) begin
        key_phase[k]  <= key_phase_next[k];
        hold_count[k] <= hold_count_next[k];
      end
      if (cfg.valid && cfg.ready) begin
        long_press_ticks <= cfg.data;
      end
    end
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || rsp.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_code   <= skid_code;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= poll_fire;
        out_code  <= poll_code;
      end
    end else if (poll_fire) begin
      skid_valid <= 1'b1;
      skid_code  <= poll_code;
    end
  end

  // The long level always tracks the long phase.
  `KSLP_ASSERT_NOW(a_long_level, clk, rst, 1'b1, long_active == phase_long)
  // The skid register only fills behind a held result.
  `KSLP_ASSERT_NOW(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  // A poll into an empty output shows its result in the next cycle.
  `KSLP_ASSERT_NEXT(a_poll_result, clk, rst, poll_fire && !out_valid,
                    out_valid && !skid_valid && (out_code == $past(poll_code)))

endmodule

[tb/sv/tb_key_short_long_press_detector_core.sv]
module tb_key_short_long_press_detector_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumKeys = kslpd_pkg::DefKeys;
  localparam int StallLimit = 1000;
  localparam int DrainCycles = 4;
  localparam int MaxReports = 10;

  // Event code bases for key 0; key k adds k.
  localparam logic [kslpd_pkg::CodeW-1:0] CodeNone = '0;
  localparam int ShortBase = 1;
  localparam int LongBase = 1 + NumKeys;
  localparam int ReleaseBase = 1 + 2 * NumKeys;

  typedef enum logic [1:0] {
    PhReleased = 2'd0,
    PhPressed = 2'd1,
    PhLong = 2'd2
  } key_phase_t;

  logic clk;
  logic rst;

  kslpd_req_if req_if ();
  kslpd_rsp_if rsp_if ();
  kslpd_cfg_if cfg_if ();

  key_short_long_press_detector_core #(
    .KEYS(NumKeys)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if),
    .cfg(cfg_if)
  );

  // Shadow of the detector state.
  logic [kslpd_pkg::TicksW-1:0] long_ticks;
  key_phase_t key_phase[NumKeys];
  logic [kslpd_pkg::TicksW-1:0] hold_ticks[NumKeys];
  logic short_flag[NumKeys];
  logic long_level[NumKeys];
  logic release_flag[NumKeys];

  logic [kslpd_pkg::CodeW-1:0] pending_codes[$];

  int idle_pct;
  int stall_pct;
  int mismatches;
  int quiet_cycles;

  // Step every key machine on one scan tick.
  function automatic void scan_keys(input logic [kslpd_pkg::LevelW-1:0] levels);
    logic down;
    for (int k = 0; k < NumKeys; k++) begin
      down = !levels[k];
      case (key_phase[k])
        PhPressed: begin
          if (!down) begin
            short_flag[k] = 1'b1;
            key_phase[k] = PhReleased;
          end else begin
            if (hold_ticks[k] != '1) hold_ticks[k] = hold_ticks[k] + 1'b1;
            if (hold_ticks[k] >= long_ticks) begin
              long_level[k] = 1'b1;
              key_phase[k] = PhLong;
            end
          end
        end
        PhLong: begin
          if (!down) begin
            release_flag[k] = 1'b1;
            long_level[k] = 1'b0;
            key_phase[k] = PhReleased;
          end
        end
        default: begin
          if (down) begin
            hold_ticks[k] = '0;
            long_level[k] = 1'b0;
            key_phase[k] = PhPressed;
          end
        end
      endcase
    end
  endfunction

  // Return the first pending event in priority order and clear sticky flags.
  function automatic logic [kslpd_pkg::CodeW-1:0] next_event();
    for (int k = 0; k < NumKeys; k++) begin
      if (short_flag[k]) begin
        short_flag[k] = 1'b0;
        return kslpd_pkg::CodeW'(k + ShortBase);
      end
      if (long_level[k]) return kslpd_pkg::CodeW'(k + LongBase);
      if (release_flag[k]) begin
        release_flag[k] = 1'b0;
        return kslpd_pkg::CodeW'(k + ReleaseBase);
      end
    end
    return CodeNone;
  endfunction

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver stalls at the rate of the current phase.
  always @(posedge clk) begin
    rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Compare each result item with the oldest expected event code.
  always @(posedge clk) begin
    logic [kslpd_pkg::CodeW-1:0] want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_codes.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("result item with nothing expected: event_code %0d", rsp_if.event_code);
      end else begin
        want = pending_codes.pop_front();
        if (rsp_if.event_code !== want) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("event_code mismatch: expected %0d, actual %0d", want,
                     rsp_if.event_code);
        end
      end
    end
  end

  // Watchdog on cycles in which no channel moves an item.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                 (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("watchdog: no item moved in %0d cycles", StallLimit);
        $display("FAIL");
        $finish;
      end
    end
  end

  // Send one item after a random gap and update the shadow state on acceptance.
  task automatic send_item(input logic act, input logic [kslpd_pkg::LevelW-1:0] levels);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.action <= act;
    req_if.key_levels <= levels;
    do @(posedge clk); while (!req_if.ready);
    if (act == kslpd_pkg::ActScan) scan_keys(levels);
    else pending_codes.push_back(next_event());
  endtask

  // Let every expected result arrive and the block settle.
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Write the long-press threshold while the block is idle.
  task automatic write_long_ticks(input logic [kslpd_pkg::TicksW-1:0] ticks);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.data <= ticks;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    long_ticks = ticks;
  endtask

  // Every event kind and the extreme codes, starting at the reset threshold.
  task automatic test_short_long_codes();
    idle_pct = 0;
    stall_pct = 0;
    send_item(kslpd_pkg::ActPoll, 4'b1111);
    send_item(kslpd_pkg::ActScan, 4'b1110);
    send_item(kslpd_pkg::ActScan, 4'b1111);
    send_item(kslpd_pkg::ActPoll, 4'b0000);
    write_long_ticks(16'd2);
    // All keys down, then keys 2 and 3 up for a short press, key 1 up too, key 0 held long.
    send_item(kslpd_pkg::ActScan, 4'b0000);
    send_item(kslpd_pkg::ActScan, 4'b1100);
    send_item(kslpd_pkg::ActScan, 4'b1110);
    send_item(kslpd_pkg::ActPoll, 4'b1111);
    send_item(kslpd_pkg::ActPoll, 4'b1111);
    send_item(kslpd_pkg::ActPoll, 4'b1111);
    send_item(kslpd_pkg::ActScan, 4'b1111);
    repeat (4) send_item(kslpd_pkg::ActPoll, 4'b1111);
    // Key 3 held long for the highest codes.
    repeat (3) send_item(kslpd_pkg::ActScan, 4'b0111);
    send_item(kslpd_pkg::ActPoll, 4'b1111);
    send_item(kslpd_pkg::ActScan, 4'b1111);
    send_item(kslpd_pkg::ActPoll, 4'b1111);
    send_item(kslpd_pkg::ActPoll, 4'b1111);
  endtask

  // A zero threshold turns a press long on the first held tick.
  task automatic test_zero_threshold();
    write_long_ticks(16'd0);
    send_item(kslpd_pkg::ActScan, 4'b1110);
    send_item(kslpd_pkg::ActPoll, 4'b1111);
    send_item(kslpd_pkg::ActScan, 4'b1110);
    send_item(kslpd_pkg::ActPoll, 4'b1111);
    send_item(kslpd_pkg::ActScan, 4'b1111);
    send_item(kslpd_pkg::ActPoll, 4'b1111);
  endtask

  // The largest threshold: a long hold stays short of it and ends as a short press.
  task automatic test_hold_ceiling();
    write_long_ticks('1);
    send_item(kslpd_pkg::ActScan, 4'b1110);
    repeat (12) send_item(kslpd_pkg::ActScan, 4'b1110);
    send_item(kslpd_pkg::ActPoll, 4'b1111);
    send_item(kslpd_pkg::ActScan, 4'b1111);
    send_item(kslpd_pkg::ActPoll, 4'b1111);
    send_item(kslpd_pkg::ActPoll, 4'b1111);
  endtask

  // Random key traffic: each key is held or let go for random runs of ticks
  // around the threshold, with polls mixed in and some noise scans.
  task automatic test_random_phase(input int gap_pct, input int stall_rate,
                                   input logic [kslpd_pkg::TicksW-1:0] ticks,
                                   input int count);
    logic [NumKeys-1:0] held;
    int unsigned key_left[NumKeys];
    int unsigned span;
    int pick;
    write_long_ticks(ticks);
    idle_pct = gap_pct;
    stall_pct = stall_rate;
    span = (ticks > 150) ? 300 : 2 * ticks + 2;
    held = '0;
    for (int k = 0; k < NumKeys; k++) key_left[k] = $urandom_range(1, span);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        send_item(kslpd_pkg::ActPoll, kslpd_pkg::LevelW'($urandom()));
      end else if (pick < 35) begin
        send_item(kslpd_pkg::ActScan, kslpd_pkg::LevelW'($urandom()));
      end else begin
        for (int k = 0; k < NumKeys; k++) begin
          if (key_left[k] == 0) begin
            held[k] = ~held[k];
            key_left[k] = $urandom_range(1, span);
          end else begin
            key_left[k]--;
          end
        end
        send_item(kslpd_pkg::ActScan, kslpd_pkg::LevelW'(~held));
      end
    end
  endtask

  // Reset, the tests in turn, then the verdict.
  initial begin
    rst = 1'b1;
    idle_pct = 0;
    stall_pct = 0;
    mismatches = 0;
    req_if.valid = 1'b0;
    req_if.action = kslpd_pkg::ActScan;
    req_if.key_levels = '1;
    rsp_if.ready = 1'b1;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    long_ticks = kslpd_pkg::TicksReset;
    for (int k = 0; k < NumKeys; k++) begin
      key_phase[k] = PhReleased;
      hold_ticks[k] = '0;
      short_flag[k] = 1'b0;
      long_level[k] = 1'b0;
      release_flag[k] = 1'b0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_short_long_codes();
    test_zero_threshold();
    test_hold_ceiling();
    test_random_phase(0, 0, 16'd1, 280);
    test_random_phase(61, 0, 16'($urandom_range(2, 16)), 280);
    test_random_phase(0, 61, kslpd_pkg::TicksReset, 280);
    test_random_phase(29, 29, 16'($urandom_range(3, 8)), 280);

    drain();
    repeat (8) @(posedge clk);
    if (pending_codes.size() != 0) begin
      mismatches++;
      $display("%0d expected result items never arrived", pending_codes.size());
    end
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/kslpd_pkg.sv
rtl/kslpd_req_if.sv
rtl/kslpd_rsp_if.sv
rtl/kslpd_cfg_if.sv
rtl/key_short_long_press_detector_core.sv
tb/sv/tb_key_short_long_press_detector_core.sv
